>>> sv/pnp_pkg.sv
`timescale 1ns / 1ps

package pnp_pkg;

  localparam int MAX_VOICES  = 8;
  localparam int STORE_DEPTH = 1024;
  localparam int PHASE_BITS  = 15;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LIM_W  = ADDR_W + 1;
  localparam int VIDX_W = $clog2(MAX_VOICES);
  localparam int VCNT_W = $clog2(MAX_VOICES + 1);
  localparam int SCAN_T_W = 19;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  note_address;
    logic [11:0] note_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sample_level;
    logic [3:0] voice_count;
    logic       led_level;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_FIRST,
    RD_LAST,
    RD_SCAN
  } rd_sel_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_TICK,
    OP_FIRST_LEN,
    OP_FIRST_STEP,
    OP_LAST_STEP,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_SCAN_DONE,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_WAIT,
    ST_F_CHK,
    ST_F_WAIT,
    ST_L_CHK,
    ST_L_WAIT,
    ST_S_RD,
    ST_S_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e     op;
    logic    rd_en;
    rd_sel_e rd_sel;
  } dp_ctl_t;

  typedef struct packed {
    logic tempo_hit;
    logic f_go;
    logic l_go;
    logic s_go;
    logic out_free;
  } dp_sts_t;

  function automatic logic [7:0] delta_of(input logic [11:0] w);
    logic [7:0] r;
    case (w[8:6])
      3'd0: r = 8'd0;
      3'd1: r = 8'd16;
      3'd2: r = 8'd32;
      3'd3: r = 8'd48;
      3'd4: r = 8'd64;
      3'd5: r = 8'd96;
      3'd6: r = 8'd144;
      default: r = 8'd192;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] dur_of(input logic [11:0] w);
    logic [9:0] r;
    case (w[11:9])
      3'd0: r = 10'd46;
      3'd1: r = 10'd48;
      3'd2: r = 10'd62;
      3'd3: r = 10'd94;
      3'd4: r = 10'd160;
      3'd5: r = 10'd528;
      3'd6: r = 10'd720;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] pitch_of(input logic [11:0] w);
    logic [10:0] r;
    case (w[5:0])
      6'd0:  r = 11'd165;
      6'd1:  r = 11'd175;
      6'd2:  r = 11'd220;
      6'd3:  r = 11'd233;
      6'd4:  r = 11'd247;
      6'd5:  r = 11'd262;
      6'd6:  r = 11'd277;
      6'd7:  r = 11'd294;
      6'd8:  r = 11'd311;
      6'd9:  r = 11'd330;
      6'd10: r = 11'd349;
      6'd11: r = 11'd370;
      6'd12: r = 11'd392;
      6'd13: r = 11'd415;
      6'd14: r = 11'd440;
      6'd15: r = 11'd466;
      6'd16: r = 11'd494;
      6'd17: r = 11'd554;
      6'd18: r = 11'd587;
      6'd19: r = 11'd622;
      6'd20: r = 11'd659;
      6'd21: r = 11'd698;
      6'd22: r = 11'd740;
      6'd23: r = 11'd784;
      6'd24: r = 11'd831;
      6'd25: r = 11'd880;
      6'd26: r = 11'd988;
      6'd27: r = 11'd1047;
      6'd28: r = 11'd1109;
      6'd29: r = 11'd1175;
      6'd30: r = 11'd1245;
      6'd31: r = 11'd1319;
      6'd32: r = 11'd1480;
      6'd33: r = 11'd1760;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + 17'(b);
    return s[16] ? SAT16 : s[15:0];
  endfunction

endpackage

>>> sv/pnp_ctrl.sv
`timescale 1ns / 1ps

module pnp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  input  pnp_pkg::dp_sts_t  sts_i,
  output pnp_pkg::dp_ctl_t  ctl_o
);

  pnp_pkg::state_e state_q, state_d;
  logic            tick_q, tick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnp_pkg::ST_IDLE;
      tick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    in_ready_o   = 1'b0;
    ctl_o.op     = pnp_pkg::OP_NONE;
    ctl_o.rd_en  = 1'b0;
    ctl_o.rd_sel = pnp_pkg::RD_ZERO;
    unique case (state_q)
      pnp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            pnp_pkg::CMD_LOAD: ctl_o.op = pnp_pkg::OP_LOAD;
            pnp_pkg::CMD_START: begin
              ctl_o.op     = pnp_pkg::OP_START;
              ctl_o.rd_en  = 1'b1;
              ctl_o.rd_sel = pnp_pkg::RD_ZERO;
              tick_d       = 1'b0;
              state_d      = pnp_pkg::ST_START_WAIT;
            end
            pnp_pkg::CMD_TICK: begin
              ctl_o.op = pnp_pkg::OP_TICK;
              tick_d   = 1'b1;
              state_d  = sts_i.tempo_hit ? pnp_pkg::ST_F_CHK : pnp_pkg::ST_OUT;
            end
            default: ctl_o.op = pnp_pkg::OP_NONE;
          endcase
        end
      end
      pnp_pkg::ST_START_WAIT: begin
        ctl_o.op = pnp_pkg::OP_FIRST_LEN;
        state_d  = pnp_pkg::ST_F_CHK;
      end
      pnp_pkg::ST_F_CHK: begin
        if (sts_i.f_go) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = pnp_pkg::RD_FIRST;
          state_d      = pnp_pkg::ST_F_WAIT;
        end else begin
          state_d = pnp_pkg::ST_L_CHK;
        end
      end
      pnp_pkg::ST_F_WAIT: begin
        ctl_o.op = pnp_pkg::OP_FIRST_STEP;
        state_d  = pnp_pkg::ST_F_CHK;
      end
      pnp_pkg::ST_L_CHK: begin
        if (sts_i.l_go) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = pnp_pkg::RD_LAST;
          state_d      = pnp_pkg::ST_L_WAIT;
        end else begin
          ctl_o.op = pnp_pkg::OP_SCAN_INIT;
          state_d  = pnp_pkg::ST_S_RD;
        end
      end
      pnp_pkg::ST_L_WAIT: begin
        ctl_o.op = pnp_pkg::OP_LAST_STEP;
        state_d  = pnp_pkg::ST_L_CHK;
      end
      pnp_pkg::ST_S_RD: begin
        if (sts_i.s_go) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = pnp_pkg::RD_SCAN;
          state_d      = pnp_pkg::ST_S_WAIT;
        end else begin
          ctl_o.op = pnp_pkg::OP_SCAN_DONE;
          state_d  = tick_q ? pnp_pkg::ST_OUT : pnp_pkg::ST_IDLE;
        end
      end
      pnp_pkg::ST_S_WAIT: begin
        ctl_o.op = pnp_pkg::OP_SCAN_STEP;
        state_d  = pnp_pkg::ST_S_RD;
      end
      pnp_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.op = pnp_pkg::OP_OUT;
          state_d  = pnp_pkg::ST_IDLE;
        end
      end
      default: state_d = pnp_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> sv/pnp_datapath.sv
`timescale 1ns / 1ps

module pnp_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pnp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pnp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  pnp_pkg::in_item_t                 in_data_i,
  input  pnp_pkg::dp_ctl_t                  ctl_i,
  output pnp_pkg::dp_sts_t                  sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pnp_pkg::out_item_t                out_data_o
);

  localparam int AW = pnp_pkg::ADDR_W;
  localparam int LW = pnp_pkg::LIM_W;
  localparam int TW = pnp_pkg::SCAN_T_W;
  localparam int NV = pnp_pkg::MAX_VOICES;

  // configuration
  logic [15:0] tempo_q;
  logic [4:0]  amp_q;
  logic [10:0] length_q;

  // song store
  logic [11:0] store_mem [pnp_pkg::STORE_DEPTH];
  logic [11:0] rdata_q;
  logic [AW-1:0] rd_addr;

  // playback state
  logic [10:0] step_q  [NV];
  logic [15:0] phase_q [NV];
  logic [pnp_pkg::VCNT_W-1:0] active_q;
  logic [15:0] div_q;
  logic [15:0] song_time_q;
  logic [AW-1:0] first_index_q, last_index_q;
  logic [15:0] first_time_q, last_time_q;
  logic [9:0]  first_len_q;
  logic        ind_q;

  // scan
  logic [LW-1:0] scan_i_q;
  logic [TW-1:0] scan_t_q;
  logic [pnp_pkg::VCNT_W-1:0] scan_n_q;

  // tick results
  logic [7:0]  sum_q;
  logic [pnp_pkg::VCNT_W-1:0] cnt_q;
  logic        out_valid_q;
  pnp_pkg::out_item_t out_q;

  logic [LW-1:0] lim, f_idx1, l_idx1;
  logic [16:0]   div_inc;
  logic [15:0]   ph_nx [NV];
  logic [7:0]    sum;
  logic [TW-1:0] t_new, song_t_ext;
  logic          hit;

  always_comb begin
    lim = (32'(length_q) > pnp_pkg::STORE_DEPTH) ? LW'(pnp_pkg::STORE_DEPTH) : LW'(length_q);
    f_idx1 = {1'b0, first_index_q} + LW'(1);
    l_idx1 = {1'b0, last_index_q} + LW'(1);
    div_inc = {1'b0, div_q} + 17'd1;

    sts_o.tempo_hit = div_inc >= {1'b0, tempo_q};
    sts_o.f_go = (f_idx1 < lim) &&
                 (({1'b0, first_time_q} + 17'(first_len_q)) <= {1'b0, song_time_q});
    sts_o.l_go = (l_idx1 < lim) && (last_time_q <= song_time_q);
    sts_o.s_go = scan_i_q <= {1'b0, last_index_q};
    sts_o.out_free = !out_valid_q || out_ready_i;

    case (ctl_i.rd_sel)
      pnp_pkg::RD_FIRST: rd_addr = f_idx1[AW-1:0];
      pnp_pkg::RD_LAST:  rd_addr = l_idx1[AW-1:0];
      pnp_pkg::RD_SCAN:  rd_addr = scan_i_q[AW-1:0];
      default:           rd_addr = '0;
    endcase

    sum = '0;
    for (int k = 0; k < NV; k++) begin
      ph_nx[k] = phase_q[k] + 16'(step_q[k]);
      if ((k < 32'(active_q)) && ph_nx[k][pnp_pkg::PHASE_BITS-1]) begin
        sum = sum + 8'(amp_q);
      end
    end

    // running onset time of the scanned word
    t_new = (scan_i_q > {1'b0, first_index_q}) ?
            scan_t_q + TW'(pnp_pkg::delta_of(rdata_q)) : scan_t_q;
    song_t_ext = TW'(song_time_q);
    hit = (song_t_ext > t_new) &&
          (song_t_ext <= t_new + TW'(pnp_pkg::dur_of(rdata_q))) &&
          (32'(scan_n_q) < NV);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == pnp_pkg::OP_LOAD && 32'(in_data_i.note_address) < pnp_pkg::STORE_DEPTH) begin
      store_mem[in_data_i.note_address[AW-1:0]] <= in_data_i.note_word;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
    if (ctl_i.op == pnp_pkg::OP_TICK) begin
      sum_q <= sum;
      cnt_q <= active_q;
    end
    if (ctl_i.op == pnp_pkg::OP_OUT) begin
      out_q.sample_level <= sum_q;
      out_q.voice_count  <= 4'(cnt_q);
      out_q.led_level    <= ind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q       <= 16'd107;
      amp_q         <= 5'd30;
      length_q      <= 11'd856;
      for (int k = 0; k < NV; k++) begin
        step_q[k]  <= '0;
        phase_q[k] <= '0;
      end
      active_q      <= '0;
      div_q         <= '0;
      song_time_q   <= '0;
      first_index_q <= '0;
      last_index_q  <= '0;
      first_time_q  <= '0;
      last_time_q   <= '0;
      first_len_q   <= '0;
      ind_q         <= 1'b0;
      scan_i_q      <= '0;
      scan_t_q      <= '0;
      scan_n_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pnp_pkg::CFG_TEMPO:  tempo_q  <= cfg_data_i;
          pnp_pkg::CFG_AMP:    amp_q    <= cfg_data_i[4:0];
          pnp_pkg::CFG_LENGTH: length_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end

      if (ctl_i.op == pnp_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (ctl_i.op)
        pnp_pkg::OP_START: begin
          for (int k = 0; k < NV; k++) begin
            step_q[k]  <= '0;
            phase_q[k] <= '0;
          end
          active_q      <= '0;
          div_q         <= '0;
          song_time_q   <= '0;
          first_index_q <= '0;
          last_index_q  <= '0;
          first_time_q  <= '0;
          last_time_q   <= '0;
          ind_q         <= 1'b1;
        end
        pnp_pkg::OP_TICK: begin
          div_q <= sts_o.tempo_hit ? 16'd0 : div_inc[15:0];
          if (sts_o.tempo_hit && song_time_q != pnp_pkg::SAT16) begin
            song_time_q <= song_time_q + 16'd1;
          end
          for (int k = 0; k < NV; k++) begin
            if (k < 32'(active_q)) phase_q[k] <= ph_nx[k];
          end
        end
        pnp_pkg::OP_FIRST_LEN: first_len_q <= pnp_pkg::dur_of(rdata_q);
        pnp_pkg::OP_FIRST_STEP: begin
          ind_q         <= ~ind_q;
          first_index_q <= f_idx1[AW-1:0];
          first_len_q   <= pnp_pkg::dur_of(rdata_q);
          first_time_q  <= pnp_pkg::sat_add16(first_time_q, pnp_pkg::delta_of(rdata_q));
        end
        pnp_pkg::OP_LAST_STEP: begin
          last_index_q <= l_idx1[AW-1:0];
          last_time_q  <= pnp_pkg::sat_add16(last_time_q, pnp_pkg::delta_of(rdata_q));
        end
        pnp_pkg::OP_SCAN_INIT: begin
          scan_i_q <= {1'b0, first_index_q};
          scan_t_q <= TW'(first_time_q);
          scan_n_q <= '0;
        end
        pnp_pkg::OP_SCAN_STEP: begin
          scan_t_q <= t_new;
          if (hit) begin
            step_q[scan_n_q[pnp_pkg::VIDX_W-1:0]] <= pnp_pkg::pitch_of(rdata_q);
            scan_n_q <= scan_n_q + pnp_pkg::VCNT_W'(1);
          end
          scan_i_q <= scan_i_q + LW'(1);
        end
        pnp_pkg::OP_SCAN_DONE: active_q <= scan_n_q;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(active_q) <= NV) else $error("active voice count above limit");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == pnp_pkg::OP_OUT |-> sts_o.out_free)
    else $error("result loaded over a pending one");

  a_out_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == pnp_pkg::OP_OUT |=> out_valid_q) else $error("result lost");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == pnp_pkg::OP_SCAN_STEP |-> 32'(scan_n_q) <= NV)
    else $error("scan voice count overflow");

endmodule

>>> sv/polyphonic_square_note_player.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | pnp_pkg::in_item_t
// out     | output    | out_valid_o / out_ready_i | pnp_pkg::out_item_t
// cfg     | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// Transactions are taken in the idle state only. A load or an unused command is
// handled without leaving idle; a tick with no tempo step goes straight to output.
// A tempo step advances the first and last windows and then scans each word of the
// note window (one store read each); a start does the same window advance and
// scan from song time zero and gives no result.
// Reset clears all playback state and loads the register defaults; the store
// holds undefined data until loaded.
// A finished tick waits in its state while the output register is full and not taken.

module polyphonic_square_note_player (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pnp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pnp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pnp_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pnp_pkg::out_item_t             out_data_o
);

  // command and status between sequencer and datapath
  pnp_pkg::dp_ctl_t ctl;
  pnp_pkg::dp_sts_t sts;

  pnp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // store, voices, windows and output register
  pnp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
